[rtl/pfr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// shared types and constants of the page frame replacement block
// no dependencies; every other file except pfr_frame_store imports this package

package pfr_pkg;

   localparam int MAX_FRAMES_DEF = 16;
   localparam int PAGE_BITS_DEF  = 16;

   localparam int PAGE_W   = 16;
   localparam int FRAME_W  = 4;
   localparam int FAULT_W  = 32;
   localparam int POLICY_W = 2;
   localparam int COUNT_W  = 5;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 1;

   localparam logic [REG_IDX_W-1:0] REG_POLICY = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_FRAMES = 1'b1;

   localparam logic [POLICY_W-1:0] POL_FIFO  = 2'd0;
   localparam logic [POLICY_W-1:0] POL_LRU   = 2'd1;
   localparam logic [POLICY_W-1:0] POL_CLOCK = 2'd2;

   localparam logic [POLICY_W-1:0] POLICY_RST = POL_FIFO;
   localparam logic [COUNT_W-1:0]  FRAMES_RST = 5'd16;

   typedef struct packed {
      logic [POLICY_W-1:0] policy;
      logic [COUNT_W-1:0]  frames;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_MOD_OLD,
      ST_MOD_LAST,
      ST_LRU,
      ST_SWEEP,
      ST_VREAD,
      ST_UPDATE
   } state_type;

   typedef enum logic [1:0] {
      KIND_HIT,
      KIND_FILL,
      KIND_REPL
   } kind_type;

   typedef enum logic {
      CMP_EQ,
      CMP_GT
   } cmp_op_type;

endpackage

`default_nettype wire

[rtl/pfr_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// request channel: one page reference per item
// depends on pfr_pkg

interface pfr_req_if;
   import pfr_pkg::*;

   logic              valid;
   logic              ready;
   logic [PAGE_W-1:0] page_number;

   modport source (output valid, output page_number, input ready);
   modport sink   (input valid, input page_number, output ready);
endinterface

`default_nettype wire

[rtl/pfr_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// response channel: lookup outcome per item
// depends on pfr_pkg

interface pfr_rsp_if;
   import pfr_pkg::*;

   logic               valid;
   logic               ready;
   logic               hit;
   logic               replaced;
   logic [FRAME_W-1:0] frame_index;
   logic [PAGE_W-1:0]  evicted_page;
   logic [FAULT_W-1:0] fault_total;

   modport source (output valid, output hit, output replaced, output frame_index,
                   output evicted_page, output fault_total, input ready);
   modport sink   (input valid, input hit, input replaced, input frame_index,
                   input evicted_page, input fault_total, output ready);
endinterface

`default_nettype wire

[rtl/pfr_csr.sv]
`timescale 1ns / 1ps
`default_nettype none
// apb-style configuration registers: policy and frame count
// depends on pfr_pkg

module pfr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [pfr_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [pfr_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [pfr_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output pfr_pkg::cfg_type                 cfg
);
   import pfr_pkg::*;

   logic [POLICY_W-1:0]  policy_ff;
   logic [COUNT_W-1:0]   frames_ff;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_RST;
         frames_ff <= FRAMES_RST;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_POLICY: policy_ff <= pwdata[POLICY_W-1:0];
            REG_FRAMES: frames_ff <= pwdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_POLICY: prdata = CSR_DATA_W'(policy_ff);
         REG_FRAMES: prdata = CSR_DATA_W'(frames_ff);
         default:    prdata = '0;
      endcase
   end

   assign cfg.policy = policy_ff;
   assign cfg.frames = frames_ff;

endmodule

`default_nettype wire

[rtl/pfr_frame_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// page number of each frame: one write port, one registered read port
// no package dependency

module pfr_frame_store #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data_ff
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[rtl/pfr_step_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// shared step unit: index increment and wrap, bound check, reduce step, compare
// depends on pfr_pkg

module pfr_step_unit #(
   parameter int CNT_W = 5,
   parameter int CMP_W = 16
) (
   input  logic [CNT_W-1:0]  op_a,
   input  logic [CNT_W-1:0]  op_lim,
   input  logic [CMP_W-1:0]  op_x,
   input  logic [CMP_W-1:0]  op_y,
   input  pfr_pkg::cmp_op_type op_cmp,
   output logic [CNT_W-1:0]  inc,
   output logic [CNT_W-1:0]  wrap,
   output logic [CNT_W-1:0]  diff,
   output logic              below,
   output logic              cmp_true
);
   import pfr_pkg::*;

   assign inc   = op_a + CNT_W'(1);
   assign wrap  = (inc == op_lim) ? '0 : inc;
   assign below = op_a < op_lim;
   assign diff  = op_a - op_lim;

   always_comb begin
      unique case (op_cmp)
         CMP_EQ:  cmp_true = op_x == op_y;
         CMP_GT:  cmp_true = op_x > op_y;
         default: cmp_true = 1'b0;
      endcase
   end

endmodule

`default_nettype wire

[rtl/page_frame_replacement.sv]
`timescale 1ns / 1ps
`default_nettype none
// page frame replacement block: sequencer, frame state and result register
// depends on pfr_pkg, pfr_req_if, pfr_rsp_if, pfr_csr, pfr_frame_store, pfr_step_unit
//
//   channel   direction  handshake            payload
//   req_ch    in         valid/ready          page_number
//   rsp_ch    out        valid/ready          hit, replaced, frame_index, evicted_page,
//                                             fault_total
//   apb       in         psel/penable/pready  paddr, pwdata, prdata
//
// n = active frames. hit or fill: accept, lookup over the active frames, update.
// full miss adds the pointer reduction steps for the oldest and last pointers,
// then fifo no search, lru a scan of all active frames or clock hand steps, plus a read.
// every step runs through the one step unit and the one frame store read port.
// synchronous reset; no clearing pass. a new item is taken only in idle;
// a held result stalls the update cycle until the output register frees.

module page_frame_replacement #(
   parameter int MAX_FRAMES = pfr_pkg::MAX_FRAMES_DEF,
   parameter int PAGE_BITS  = pfr_pkg::PAGE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   pfr_req_if.sink                         req_ch,
   pfr_rsp_if.source                       rsp_ch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [pfr_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [pfr_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [pfr_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import pfr_pkg::*;

   localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int NW = $clog2(MAX_FRAMES + 1);
   localparam int KW = (PAGE_BITS > IW) ? PAGE_BITS : IW;

   cfg_type cfg;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;

   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [NW-1:0]        n_ff, n_in, n_cfg;
   logic [NW-1:0]        idx_ff, idx_in;
   logic [IW-1:0]        idx_lo;
   logic                 chk_ff, chk_in;
   logic [IW-1:0]        chk_idx_ff, chk_idx_in;
   logic                 have_ff, have_in;
   logic [IW-1:0]        best_ff, best_in;
   logic [IW-1:0]        vic_ff, vic_in;

   logic [MAX_FRAMES-1:0] valid_ff;
   logic [MAX_FRAMES-1:0] use_ff;
   logic [IW-1:0]         rank_ff [MAX_FRAMES];
   logic [IW-1:0]         oldest_ff, oldest_in;
   logic [IW-1:0]         last_ff, last_in;
   logic [NW-1:0]         filled_ff;
   logic [FAULT_W-1:0]    fault_ff, fault_nx;

   logic                 rsp_vld_ff;
   logic                 rsp_hit_ff;
   logic                 rsp_repl_ff;
   logic [FRAME_W-1:0]   rsp_frame_ff;
   logic [PAGE_W-1:0]    rsp_evict_ff;
   logic [FAULT_W-1:0]   rsp_fault_ff;

   logic                 req_fire;
   logic                 use_clr;
   logic                 upd_en;
   logic                 mem_we;
   logic [PAGE_BITS-1:0] rd_data;
   logic [IW-1:0]        rank_rd;
   logic [NW-1:0]        rank_old;

   logic [NW-1:0]        op_a;
   logic [KW-1:0]        op_x, op_y;
   cmp_op_type           op_cmp;
   logic [NW-1:0]        inc, wrap, diff;
   logic                 below, cmp_true;

   pfr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pfr_frame_store #(
      .DEPTH  (MAX_FRAMES),
      .ADDR_W (IW),
      .DATA_W (PAGE_BITS)
   ) u_store (
      .clock      (clock),
      .wr_en      (mem_we),
      .wr_addr    (idx_lo),
      .wr_data    (page_ff),
      .rd_addr    (idx_lo),
      .rd_data_ff (rd_data)
   );

   pfr_step_unit #(
      .CNT_W (NW),
      .CMP_W (KW)
   ) u_step (
      .op_a     (op_a),
      .op_lim   (n_ff),
      .op_x     (op_x),
      .op_y     (op_y),
      .op_cmp   (op_cmp),
      .inc      (inc),
      .wrap     (wrap),
      .diff     (diff),
      .below    (below),
      .cmp_true (cmp_true)
   );

   assign idx_lo   = idx_ff[IW-1:0];
   assign rank_rd  = rank_ff[idx_lo];
   assign rank_old = valid_ff[idx_lo] ? NW'(rank_rd) : NW'(MAX_FRAMES);
   assign fault_nx = (&fault_ff) ? fault_ff : fault_ff + FAULT_W'(1);

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid        = rsp_vld_ff;
   assign rsp_ch.hit          = rsp_hit_ff;
   assign rsp_ch.replaced     = rsp_repl_ff;
   assign rsp_ch.frame_index  = rsp_frame_ff;
   assign rsp_ch.evicted_page = rsp_evict_ff;
   assign rsp_ch.fault_total  = rsp_fault_ff;

   // active frame count
   always_comb begin
      if (cfg.frames == '0) begin
         n_cfg = NW'(1);
      end else if (int'(cfg.frames) > MAX_FRAMES) begin
         n_cfg = NW'(MAX_FRAMES);
      end else begin
         n_cfg = NW'(cfg.frames);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            if (chk_ff && cmp_true) begin
               state_in = ST_UPDATE;
            end else if (!below) begin
               state_in = (filled_ff < n_ff) ? ST_UPDATE : ST_MOD_OLD;
            end
         end
         ST_MOD_OLD: begin
            if (below) state_in = ST_MOD_LAST;
         end
         ST_MOD_LAST: begin
            if (below) begin
               unique case (cfg.policy)
                  POL_LRU:   state_in = ST_LRU;
                  POL_CLOCK: state_in = ST_SWEEP;
                  default:   state_in = ST_VREAD;
               endcase
            end
         end
         ST_LRU: begin
            if (!below) state_in = ST_VREAD;
         end
         ST_SWEEP: begin
            if (!use_ff[idx_lo]) state_in = ST_VREAD;
         end
         ST_VREAD: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (!rsp_vld_ff || rsp_ch.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      idx_in     = idx_ff;
      chk_in     = 1'b0;
      chk_idx_in = chk_idx_ff;
      kind_in    = kind_ff;
      have_in    = have_ff;
      best_in    = best_ff;
      vic_in     = vic_ff;
      oldest_in  = oldest_ff;
      last_in    = last_ff;
      page_in    = page_ff;
      n_in       = n_ff;
      use_clr    = 1'b0;
      upd_en     = 1'b0;
      mem_we     = 1'b0;
      op_a       = idx_ff;
      op_x       = KW'(rd_data);
      op_y       = KW'(page_ff);
      op_cmp     = CMP_EQ;
      unique case (state_ff)
         ST_IDLE: begin
            page_in = PAGE_BITS'(req_ch.page_number);
            n_in    = n_cfg;
            idx_in  = '0;
         end
         ST_LOOK: begin
            if (chk_ff && cmp_true) begin
               kind_in = KIND_HIT;
               idx_in  = NW'(chk_idx_ff);
            end else if (!below) begin
               if (filled_ff < n_ff) begin
                  kind_in = KIND_FILL;
                  idx_in  = filled_ff;
               end else begin
                  kind_in = KIND_REPL;
               end
            end else begin
               chk_in     = valid_ff[idx_lo];
               chk_idx_in = idx_lo;
               idx_in     = inc;
            end
         end
         ST_MOD_OLD: begin
            op_a = NW'(oldest_ff);
            if (!below) oldest_in = IW'(diff);
         end
         ST_MOD_LAST: begin
            op_a = NW'(last_ff);
            if (!below) begin
               last_in = IW'(diff);
            end else begin
               unique case (cfg.policy)
                  POL_LRU: begin
                     idx_in  = '0;
                     have_in = 1'b0;
                     best_in = '0;
                     vic_in  = '0;
                  end
                  POL_CLOCK: idx_in = wrap;
                  default:   idx_in = NW'(oldest_ff);
               endcase
            end
         end
         ST_LRU: begin
            op_x   = KW'(rank_rd);
            op_y   = KW'(best_ff);
            op_cmp = CMP_GT;
            if (below) begin
               if (valid_ff[idx_lo] && (!have_ff || cmp_true)) begin
                  best_in = rank_rd;
                  vic_in  = idx_lo;
                  have_in = 1'b1;
               end
               idx_in = inc;
            end else begin
               idx_in = NW'(vic_ff);
            end
         end
         ST_SWEEP: begin
            if (use_ff[idx_lo]) begin
               use_clr = 1'b1;
               idx_in  = wrap;
            end
         end
         ST_VREAD: ;
         ST_UPDATE: begin
            upd_en = !rsp_vld_ff || rsp_ch.ready;
            mem_we = upd_en && (kind_ff != KIND_HIT);
            if (upd_en && (kind_ff != KIND_HIT)) last_in = idx_lo;
            if (upd_en && (kind_ff == KIND_REPL)) oldest_in = IW'(wrap);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff    <= page_in;
      n_ff       <= n_in;
      idx_ff     <= idx_in;
      chk_idx_ff <= chk_idx_in;
      kind_ff    <= kind_in;
      have_ff    <= have_in;
      best_ff    <= best_in;
      vic_ff     <= vic_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_ff    <= 1'b0;
         valid_ff  <= '0;
         use_ff    <= '0;
         oldest_ff <= '0;
         last_ff   <= '0;
         filled_ff <= '0;
         fault_ff  <= '0;
         for (int j = 0; j < MAX_FRAMES; j++) begin
            rank_ff[j] <= '0;
         end
      end else begin
         chk_ff    <= chk_in;
         oldest_ff <= oldest_in;
         last_ff   <= last_in;
         if (use_clr) use_ff[idx_lo] <= 1'b0;
         if (upd_en) begin
            // promote frame to most recent, age the younger ones
            for (int j = 0; j < MAX_FRAMES; j++) begin
               if ((IW'(j) != idx_lo) && valid_ff[j] && (NW'(rank_ff[j]) < rank_old) &&
                   (rank_ff[j] < IW'(MAX_FRAMES - 1))) begin
                  rank_ff[j] <= rank_ff[j] + IW'(1);
               end
            end
            rank_ff[idx_lo] <= '0;
            use_ff[idx_lo]  <= 1'b1;
            if (kind_ff != KIND_HIT) valid_ff[idx_lo] <= 1'b1;
            if (kind_ff == KIND_FILL) filled_ff <= filled_ff + NW'(1);
            if (kind_ff == KIND_REPL) fault_ff <= fault_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (upd_en) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_en) begin
         rsp_hit_ff   <= (kind_ff == KIND_HIT);
         rsp_repl_ff  <= (kind_ff == KIND_REPL);
         rsp_frame_ff <= FRAME_W'(idx_lo);
         rsp_evict_ff <= ((kind_ff == KIND_REPL) && valid_ff[idx_lo]) ?
                         PAGE_W'(rd_data) : '0;
         rsp_fault_ff <= (kind_ff == KIND_REPL) ? fault_nx : fault_ff;
      end
   end

`ifndef ASSERT_OFF
   a_filled_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(filled_ff))
      else $error("filled count differs from resident frames");

   a_hand_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (idx_ff < n_ff))
      else $error("clock hand beyond active frames");

   a_result_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("result raised outside update");

   a_fault_monotonic: assert property (@(posedge clock) disable iff (reset)
      (!reset) |=> (fault_ff >= $past(fault_ff)))
      else $error("fault count went down");
`endif

endmodule

`default_nettype wire
